[src/vec3_pkg.sv]
// ----------------------------------------------------------------------------
// vec3_pkg: shared types and helpers for the three-component vector ALU
// Word format, operation codes, beat structs and the saturation helpers that
// the front end, the root pipeline and the divider pipeline all use.
// ----------------------------------------------------------------------------
package vec3_pkg;

	localparam int WORD_BITS     = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PROD_BITS     = 2 * WORD_BITS;

	// Operation codes carried in the kind field; six and seven are unused.
	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_SCALE = 3'd2,
		OP_DOT   = 3'd3,
		OP_LEN   = 3'd4,
		OP_NORM  = 3'd5
	} op_e;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-1:0]        mag_t;
	typedef logic [PROD_BITS-1:0]        prod_t;

	// Input beat.
	typedef struct packed {
		logic [2:0] kind;
		word_t      ax;
		word_t      ay;
		word_t      az;
		word_t      bx;
		word_t      by;
		word_t      bz;
		word_t      scale_factor;
	} args_t;

	// Result beat.
	typedef struct packed {
		word_t rx;
		word_t ry;
		word_t rz;
		word_t rscalar;
		logic  saturated;
	} result_t;

	// What travels down the pipeline next to the arithmetic.
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] neg;
		mag_t       mx;
		mag_t       my;
		mag_t       mz;
		result_t    res;
	} lane_t;

	typedef struct packed {
		word_t val;
		logic  sat;
	} clip_t;

	// Magnitude of a signed word; the most negative word maps to its true size.
	function automatic mag_t abs_word(word_t x);
		return x[WORD_BITS-1] ? (mag_t'(0) - mag_t'(x)) : mag_t'(x);
	endfunction

	// Apply a sign to a magnitude and saturate to the word range.
	function automatic clip_t clip_mag(logic neg, prod_t m);
		prod_t lim;
		clip_t c;
		lim = (prod_t'(1) << (WORD_BITS - 1)) - {{(PROD_BITS-1){1'b0}}, ~neg};
		if (m > lim) begin
			c.sat = 1'b1;
			c.val = neg ? word_t'({1'b1, {(WORD_BITS-1){1'b0}}})
			            : word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
		end else begin
			c.sat = 1'b0;
			c.val = neg ? word_t'(mag_t'(0) - m[WORD_BITS-1:0])
			            : word_t'(m[WORD_BITS-1:0]);
		end
		return c;
	endfunction

	// Saturating add or subtract of two words.
	function automatic clip_t clip_sum(word_t a, word_t b, logic sub);
		logic signed [WORD_BITS:0] t;
		clip_t c;
		t = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
		        : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
		if (t[WORD_BITS] != t[WORD_BITS-1]) begin
			c.sat = 1'b1;
			c.val = t[WORD_BITS] ? word_t'({1'b1, {(WORD_BITS-1){1'b0}}})
			                     : word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
		end else begin
			c.sat = 1'b0;
			c.val = t[WORD_BITS-1:0];
		end
		return c;
	endfunction

endpackage

[src/vec3_front.sv]
// ----------------------------------------------------------------------------
// vec3_front: operand preparation, products and scalar results
// Four stages: magnitudes and add/subtract, three shared multipliers, signed
// sum plus scale rounding, then dot rounding. Hands the sum of squares on.
// ----------------------------------------------------------------------------
module vec3_front #(
	parameter int FRAC_BITS = vec3_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  vec3_pkg::args_t   args,
	output logic              out_vld,
	output vec3_pkg::lane_t   lane,
	output vec3_pkg::prod_t   radicand
);

	localparam int W  = vec3_pkg::WORD_BITS;
	localparam int PW = vec3_pkg::PROD_BITS;
	localparam vec3_pkg::prod_t HALF = vec3_pkg::prod_t'(1) << (FRAC_BITS - 1);

	// Stage 1: magnitudes, multiplier operand select, add and subtract.
	vec3_pkg::mag_t  mo [3];
	logic [2:0]      pn;
	vec3_pkg::lane_t lane1;
	vec3_pkg::clip_t cx, cy, cz;

	always_comb begin
		lane1      = '0;
		lane1.kind = args.kind;
		lane1.neg  = {args.az[W-1], args.ay[W-1], args.ax[W-1]};
		lane1.mx   = vec3_pkg::abs_word(args.ax);
		lane1.my   = vec3_pkg::abs_word(args.ay);
		lane1.mz   = vec3_pkg::abs_word(args.az);
		unique case (args.kind)
			vec3_pkg::OP_SCALE: begin
				mo[0] = vec3_pkg::abs_word(args.scale_factor);
				mo[1] = vec3_pkg::abs_word(args.scale_factor);
				mo[2] = vec3_pkg::abs_word(args.scale_factor);
				pn    = {3{args.scale_factor[W-1]}} ^ lane1.neg;
			end
			vec3_pkg::OP_DOT: begin
				mo[0] = vec3_pkg::abs_word(args.bx);
				mo[1] = vec3_pkg::abs_word(args.by);
				mo[2] = vec3_pkg::abs_word(args.bz);
				pn    = {args.bz[W-1], args.by[W-1], args.bx[W-1]} ^ lane1.neg;
			end
			default: begin
				mo[0] = lane1.mx;
				mo[1] = lane1.my;
				mo[2] = lane1.mz;
				pn    = 3'b000;
			end
		endcase
		cx = vec3_pkg::clip_sum(args.ax, args.bx, args.kind == vec3_pkg::OP_SUB);
		cy = vec3_pkg::clip_sum(args.ay, args.by, args.kind == vec3_pkg::OP_SUB);
		cz = vec3_pkg::clip_sum(args.az, args.bz, args.kind == vec3_pkg::OP_SUB);
		if (args.kind == vec3_pkg::OP_ADD || args.kind == vec3_pkg::OP_SUB) begin
			lane1.res.rx        = cx.val;
			lane1.res.ry        = cy.val;
			lane1.res.rz        = cz.val;
			lane1.res.saturated = cx.sat | cy.sat | cz.sat;
		end
	end

	logic            vld_s1, vld_s2, vld_s3, vld_s4;
	vec3_pkg::lane_t lane_s1, lane_s2, lane_s3, lane_s4;
	vec3_pkg::mag_t  mo_s1 [3];
	logic [2:0]      pn_s1, pn_s2;
	vec3_pkg::prod_t p_s2 [3];
	logic signed [PW+1:0] sum_s3;
	vec3_pkg::prod_t rad_s4;

	// Valid bits follow the beat through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= lane1;
		mo_s1   <= mo;
		pn_s1   <= pn;
	end

	// Stage 2: three magnitude products.
	always_ff @(posedge clk) begin
		lane_s2 <= lane_s1;
		pn_s2   <= pn_s1;
		p_s2[0] <= vec3_pkg::prod_t'(lane_s1.mx) * vec3_pkg::prod_t'(mo_s1[0]);
		p_s2[1] <= vec3_pkg::prod_t'(lane_s1.my) * vec3_pkg::prod_t'(mo_s1[1]);
		p_s2[2] <= vec3_pkg::prod_t'(lane_s1.mz) * vec3_pkg::prod_t'(mo_s1[2]);
	end

	// Stage 3: exact signed sum for dot and length, rounded scale components.
	logic signed [PW+1:0] sp [3];
	vec3_pkg::clip_t      sc [3];
	vec3_pkg::lane_t      lane3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sp[i] = pn_s2[i] ? -$signed({2'b00, p_s2[i]}) : $signed({2'b00, p_s2[i]});
			sc[i] = vec3_pkg::clip_mag(pn_s2[i], (p_s2[i] + HALF) >> FRAC_BITS);
		end
		lane3 = lane_s2;
		if (lane_s2.kind == vec3_pkg::OP_SCALE) begin
			lane3.res.rx        = sc[0].val;
			lane3.res.ry        = sc[1].val;
			lane3.res.rz        = sc[2].val;
			lane3.res.saturated = sc[0].sat | sc[1].sat | sc[2].sat;
		end
	end

	always_ff @(posedge clk) begin
		lane_s3 <= lane3;
		sum_s3  <= sp[0] + sp[1] + sp[2];
	end

	// Stage 4: dot product rounded on its magnitude and saturated.
	logic [PW+1:0]   dmag;
	vec3_pkg::clip_t dc;
	vec3_pkg::lane_t lane4;

	always_comb begin
		dmag  = sum_s3[PW+1] ? (PW+2)'(-sum_s3) : (PW+2)'(sum_s3);
		dc    = vec3_pkg::clip_mag(sum_s3[PW+1], (dmag[PW-1:0] + HALF) >> FRAC_BITS);
		lane4 = lane_s3;
		if (lane_s3.kind == vec3_pkg::OP_DOT) begin
			lane4.res.rscalar   = dc.val;
			lane4.res.saturated = dc.sat;
		end
	end

	always_ff @(posedge clk) begin
		lane_s4 <= lane4;
		rad_s4  <= sum_s3[PW-1:0];
	end

	assign out_vld  = vld_s4;
	assign lane     = lane_s4;
	assign radicand = rad_s4;

endmodule

[src/vec3_sqrt.sv]
// ----------------------------------------------------------------------------
// vec3_sqrt: pipelined integer square root with round to nearest
// One root bit per stage from the top, on the running remainder, then one
// stage that rounds the root and finishes the length operation.
// ----------------------------------------------------------------------------
module vec3_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  vec3_pkg::lane_t          in_lane,
	input  vec3_pkg::prod_t          radicand,
	output logic                     out_vld,
	output vec3_pkg::lane_t          lane,
	output logic [vec3_pkg::WORD_BITS:0] len
);

	localparam int W  = vec3_pkg::WORD_BITS;
	localparam int PW = vec3_pkg::PROD_BITS;

	logic            vld_s  [W+1];
	vec3_pkg::lane_t lane_s [W+1];
	logic [PW:0]     rem_s  [W+1];
	vec3_pkg::mag_t  root_s [W+1];

	assign vld_s[0]  = in_vld;
	assign lane_s[0] = in_lane;
	assign rem_s[0]  = {1'b0, radicand};
	assign root_s[0] = '0;

	// Each stage tries the next lower root bit against the remainder.
	for (genvar k = 0; k < W; k++) begin : g_bit
		localparam int B = W - 1 - k;
		logic [PW:0] trial;

		assign trial = ((PW+1)'(root_s[k]) << (B + 1)) + ((PW+1)'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			lane_s[k+1] <= lane_s[k];
			if (rem_s[k] >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= root_s[k] | (vec3_pkg::mag_t'(1) << B);
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	// Round up when the remainder passes the root, and finish length.
	logic [W:0]      len_d;
	vec3_pkg::clip_t lc;
	vec3_pkg::lane_t lane_d;
	logic            vld_q;
	vec3_pkg::lane_t lane_q;
	logic [W:0]      len_q;

	always_comb begin
		len_d  = {1'b0, root_s[W]} +
		         (W+1)'(rem_s[W] > (PW+1)'(root_s[W]));
		lc     = vec3_pkg::clip_mag(1'b0, vec3_pkg::prod_t'(len_d));
		lane_d = lane_s[W];
		if (lane_s[W].kind == vec3_pkg::OP_LEN) begin
			lane_d.res.rscalar   = lc.val;
			lane_d.res.saturated = lc.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[W];
		end
	end

	always_ff @(posedge clk) begin
		lane_q <= lane_d;
		len_q  <= len_d;
	end

	assign out_vld = vld_q;
	assign lane    = lane_q;
	assign len     = len_q;

endmodule

[src/vec3_div.sv]
// ----------------------------------------------------------------------------
// vec3_div: pipelined three-lane divider for normalize
// Divides each component magnitude, scaled by the fraction, by the length,
// one quotient bit per stage, then rounds, signs and saturates.
// ----------------------------------------------------------------------------
module vec3_div #(
	parameter int FRAC_BITS = vec3_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  vec3_pkg::lane_t              in_lane,
	input  logic [vec3_pkg::WORD_BITS:0] len,
	output logic                         out_vld,
	output logic [2:0]                   kind,
	output vec3_pkg::result_t            result
);

	localparam int W  = vec3_pkg::WORD_BITS;
	localparam int NW = W + FRAC_BITS + 1;
	localparam int QW = FRAC_BITS + 1;

	logic            vld_s  [QW+1];
	vec3_pkg::lane_t lane_s [QW+1];
	logic [W:0]      den_s  [QW+1];
	logic [NW-1:0]   rem_s  [QW+1][3];
	logic [QW-1:0]   quo_s  [QW+1][3];

	assign vld_s[0]    = in_vld;
	assign lane_s[0]   = in_lane;
	assign den_s[0]    = len;
	assign rem_s[0][0] = NW'(in_lane.mx) << FRAC_BITS;
	assign rem_s[0][1] = NW'(in_lane.my) << FRAC_BITS;
	assign rem_s[0][2] = NW'(in_lane.mz) << FRAC_BITS;
	assign quo_s[0][0] = '0;
	assign quo_s[0][1] = '0;
	assign quo_s[0][2] = '0;

	// The quotient stays below two to the fraction width plus one.
	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int B = QW - 1 - k;
		logic [NW-1:0] trial;

		assign trial = NW'(den_s[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			lane_s[k+1] <= lane_s[k];
			den_s[k+1]  <= den_s[k];
			for (int j = 0; j < 3; j++) begin
				if (rem_s[k][j] >= trial) begin
					rem_s[k+1][j] <= rem_s[k][j] - trial;
					quo_s[k+1][j] <= quo_s[k][j] | (QW'(1) << B);
				end else begin
					rem_s[k+1][j] <= rem_s[k][j];
					quo_s[k+1][j] <= quo_s[k][j];
				end
			end
		end
	end

	// Round half up on the remainder, apply signs, fill the vector result.
	logic [QW:0]       qr [3];
	vec3_pkg::clip_t   nc [3];
	vec3_pkg::result_t res_d;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qr[j] = {1'b0, quo_s[QW][j]} +
			        (QW+1)'(({1'b0, rem_s[QW][j]} << 1) >= (NW+1)'(den_s[QW]));
			nc[j] = vec3_pkg::clip_mag(lane_s[QW].neg[j], vec3_pkg::prod_t'(qr[j]));
		end
		res_d = lane_s[QW].res;
		if (lane_s[QW].kind == vec3_pkg::OP_NORM && den_s[QW] != '0) begin
			res_d.rx        = nc[0].val;
			res_d.ry        = nc[1].val;
			res_d.rz        = nc[2].val;
			res_d.saturated = nc[0].sat | nc[1].sat | nc[2].sat;
		end
	end

	logic              vld_q;
	logic [2:0]        kind_q;
	vec3_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= lane_s[QW].kind;
		res_q  <= res_d;
	end

	assign out_vld = vld_q;
	assign kind    = kind_q;
	assign result  = res_q;

endmodule

[src/vector3_alu.sv]
// ----------------------------------------------------------------------------
// vector3_alu: pipelined Q16.16 three-component vector ALU
// Add, subtract, scale, dot, length and normalize with saturation flag.
//
//   channel   handshake      payload            direction
//   command   start / busy   args   (args_t)    in
//   result    done           result (result_t)  out
//
// A beat is taken on every edge with start high; busy stays low.
// Every operation takes the same path: four front stages, one stage per
// root bit of the 32-bit length, one stage per quotient bit of the
// normalize divider, and three end stages (root rounding, divider output
// and the output register).
// Reset clears only the valid bits, so results already in flight are dropped.
// The receiver cannot stall; each result shows for one cycle with done.
// ----------------------------------------------------------------------------
module vector3_alu #(
	parameter int FRAC_BITS = vec3_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vec3_pkg::args_t   args,
	output logic              done,
	output vec3_pkg::result_t result
);

	logic                         f_vld, r_vld, d_vld;
	vec3_pkg::lane_t              f_lane, r_lane;
	vec3_pkg::prod_t              f_rad;
	logic [vec3_pkg::WORD_BITS:0] r_len;
	logic [2:0]                   d_kind;
	vec3_pkg::result_t            d_res;

	// The pipeline never holds off a command.
	assign busy = 1'b0;

	vec3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.args     (args),
		.out_vld  (f_vld),
		.lane     (f_lane),
		.radicand (f_rad)
	);

	vec3_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (f_vld),
		.in_lane  (f_lane),
		.radicand (f_rad),
		.out_vld  (r_vld),
		.lane     (r_lane),
		.len      (r_len)
	);

	vec3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (r_vld),
		.in_lane (r_lane),
		.len     (r_len),
		.out_vld (d_vld),
		.kind    (d_kind),
		.result  (d_res)
	);

	// Output register.
	logic              done_q;
	logic [2:0]        kind_q;
	vec3_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= d_kind;
		result_q <= d_res;
	end

	assign done   = done_q;
	assign result = result_q;

	// Scalar operations leave the vector fields clear.
	a_scalar_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind_q == vec3_pkg::OP_DOT || kind_q == vec3_pkg::OP_LEN)
		|-> result.rx == '0 && result.ry == '0 && result.rz == '0)
		else $error("vector field set on a scalar result");

	// Vector operations leave the scalar field clear.
	a_vector_scalar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind_q == vec3_pkg::OP_ADD || kind_q == vec3_pkg::OP_SUB ||
		         kind_q == vec3_pkg::OP_SCALE || kind_q == vec3_pkg::OP_NORM)
		|-> result.rscalar == '0)
		else $error("scalar field set on a vector result");

	// A length is never negative.
	a_len_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind_q == vec3_pkg::OP_LEN |-> !result.rscalar[vec3_pkg::WORD_BITS-1])
		else $error("negative length");

	// Unused codes give an all-zero result.
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind_q[2] && kind_q[1] |-> result == '0)
		else $error("unused code gave a nonzero result");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the three-component vector ALU
// A queue of command beats feeds a clocked driver. Each accepted beat is
// predicted at full width and the expected result is queued. A clocked
// monitor compares every done beat, field by field, with the oldest expected
// result. The sender idles at random in some phases and not at all in others.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import vec3_pkg::*;

	localparam int FB         = FRAC_BITS_DEF;
	localparam int LATENCY    = FB + 40;
	localparam int N_RANDOM   = 1650;
	localparam int LIMIT      = 400000;

	typedef logic [127:0] wide_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	args_t   args = '0;
	logic    done;
	result_t result;

	args_t   cmd_q[$];
	result_t want_q[$];
	int      n_errors = 0;
	int      n_total = 0;
	int      n_sent = 0;
	int      cycles = 0;

	vector3_alu dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.args   (args),
		.done   (done),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Magnitude of a signed word at full width.
	function automatic wide_t mag128(word_t x);
		return x[WORD_BITS-1] ? wide_t'(-64'(x)) : wide_t'(x);
	endfunction

	// Round to nearest with ties away from zero, dropping the fraction.
	function automatic wide_t round_frac(wide_t m);
		return (m + (wide_t'(1) << (FB - 1))) >> FB;
	endfunction

	// Apply a sign to a magnitude, saturating to the word range.
	function automatic word_t sat_signed(logic neg, wide_t m, inout logic sat);
		wide_t lim;
		lim = neg ? (wide_t'(1) << (WORD_BITS - 1)) : (wide_t'(1) << (WORD_BITS - 1)) - 1;
		if (m > lim) begin
			sat = 1'b1;
			m = lim;
		end
		return neg ? word_t'(-m[WORD_BITS-1:0]) : word_t'(m[WORD_BITS-1:0]);
	endfunction

	// Rounded square root of the sum of squares of vector a.
	function automatic wide_t vec_length(word_t x, word_t y, word_t z);
		wide_t s, r, c;
		s = mag128(x) * mag128(x) + mag128(y) * mag128(y) + mag128(z) * mag128(z);
		r = 0;
		for (int b = 49; b >= 0; b--) begin
			c = r | (wide_t'(1) << b);
			if (c * c <= s)
				r = c;
		end
		if (s - r * r > r)
			r = r + 1;
		return r;
	endfunction

	// Expected result beat for one command beat.
	function automatic result_t alu_predict(args_t a);
		result_t res;
		logic    sat;
		word_t   av[3], bv[3];
		logic signed [WORD_BITS:0] t;
		wide_t   pos, negs, p, len, num, q, rem;
		logic    ng;
		res = '0;
		sat = 1'b0;
		av = '{a.ax, a.ay, a.az};
		bv = '{a.bx, a.by, a.bz};
		case (a.kind)
			OP_ADD, OP_SUB: begin
				for (int i = 0; i < 3; i++) begin
					t = (a.kind == OP_ADD) ? ($signed({av[i][31], av[i]}) + $signed({bv[i][31], bv[i]}))
					                       : ($signed({av[i][31], av[i]}) - $signed({bv[i][31], bv[i]}));
					if (t > 33'sd2147483647) begin
						sat = 1'b1; av[i] = 32'h7fffffff;
					end else if (t < -33'sd2147483648) begin
						sat = 1'b1; av[i] = 32'h80000000;
					end else
						av[i] = t[31:0];
				end
				res.rx = av[0]; res.ry = av[1]; res.rz = av[2];
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++)
					av[i] = sat_signed(av[i][31] != a.scale_factor[31],
						round_frac(mag128(av[i]) * mag128(a.scale_factor)), sat);
				res.rx = av[0]; res.ry = av[1]; res.rz = av[2];
			end
			OP_DOT: begin
				pos = 0; negs = 0;
				for (int i = 0; i < 3; i++) begin
					p = mag128(av[i]) * mag128(bv[i]);
					if (av[i][31] != bv[i][31]) negs += p;
					else pos += p;
				end
				ng = pos < negs;
				res.rscalar = sat_signed(ng, round_frac(ng ? negs - pos : pos - negs), sat);
			end
			OP_LEN: begin
				res.rscalar = sat_signed(1'b0, vec_length(a.ax, a.ay, a.az), sat);
			end
			OP_NORM: begin
				len = vec_length(a.ax, a.ay, a.az);
				// A zero vector has zero length and normalizes to all zero.
				if (len != 0) begin
					for (int i = 0; i < 3; i++) begin
						num = mag128(av[i]) << FB;
						q = num / len;
						rem = num % len;
						if (rem >= len - rem) q = q + 1;
						av[i] = sat_signed(av[i][31], q, sat);
					end
					res.rx = av[0]; res.ry = av[1]; res.rz = av[2];
				end
			end
			default: ;
		endcase
		res.saturated = sat;
		return res;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			1: return word_t'($urandom_range(0, 32'hfffff)) - 32'sh80000;
			2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
			                                : 32'h80000000 + $urandom_range(0, 3);
			3: return 32'sd0;
			default: return word_t'($urandom());
		endcase
	endfunction

	function automatic args_t rand_cmd();
		args_t c;
		c.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		c.ax = rand_word(); c.ay = rand_word(); c.az = rand_word();
		c.bx = rand_word(); c.by = rand_word(); c.bz = rand_word();
		c.scale_factor = rand_word();
		return c;
	endfunction

	function automatic args_t mk(logic [2:0] k, word_t x, word_t y, word_t z,
		word_t u, word_t v, word_t w, word_t s);
		args_t c;
		c.kind = k; c.ax = x; c.ay = y; c.az = z;
		c.bx = u; c.by = v; c.bz = w; c.scale_factor = s;
		return c;
	endfunction

	// Driver: one beat is taken on each edge with start high and busy low.
	always @(posedge clk) begin
		int idle_pct;
		if (arst_n) begin
			if (start && !busy) begin
				want_q.push_back(alu_predict(args));
				n_sent = n_sent + 1;
			end
			if (!start || !busy) begin
				case ((n_sent * 4) / (n_total + 1))
					1: idle_pct = 69;
					3: idle_pct = 30;
					default: idle_pct = 0;
				endcase
				if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					args  <= cmd_q.pop_front();
					start <= 1'b1;
				end else
					start <= 1'b0;
			end
		end
	end

	// Monitor: every done beat is checked against the oldest expected result.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (want_q.size() == 0) begin
				$error("result beat with nothing expected");
				n_errors = n_errors + 1;
			end else begin
				exp_r = want_q.pop_front();
				if (result.rx !== exp_r.rx) begin
					$error("rx expected %h got %h", exp_r.rx, result.rx);
					n_errors = n_errors + 1;
				end
				if (result.ry !== exp_r.ry) begin
					$error("ry expected %h got %h", exp_r.ry, result.ry);
					n_errors = n_errors + 1;
				end
				if (result.rz !== exp_r.rz) begin
					$error("rz expected %h got %h", exp_r.rz, result.rz);
					n_errors = n_errors + 1;
				end
				if (result.rscalar !== exp_r.rscalar) begin
					$error("rscalar expected %h got %h", exp_r.rscalar, result.rscalar);
					n_errors = n_errors + 1;
				end
				if (result.saturated !== exp_r.saturated) begin
					$error("saturated expected %b got %b", exp_r.saturated, result.saturated);
					n_errors = n_errors + 1;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		word_t mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		// Directed beats: extremes, every operation, unused codes.
		cmd_q.push_back(mk(OP_ADD, mx, mn, 1, 1, mn, -1, 0));
		cmd_q.push_back(mk(OP_SUB, mx, mn, 0, mn, 1, 0, 0));
		cmd_q.push_back(mk(OP_SUB, 5, -7, mn, -3, 2, mx, mx));
		cmd_q.push_back(mk(OP_SCALE, mx, mn, 32'h10000, 0, 0, 0, mn));
		cmd_q.push_back(mk(OP_SCALE, 32'h18000, -32'h8000, 3, 0, 0, 0, 32'h8000));
		cmd_q.push_back(mk(OP_SCALE, 1, -1, 32'h7fff, 0, 0, 0, 32'h8000));
		cmd_q.push_back(mk(OP_DOT, mx, mx, mx, mx, mx, mx, 0));
		cmd_q.push_back(mk(OP_DOT, mn, mn, mn, mx, mx, mx, 0));
		cmd_q.push_back(mk(OP_DOT, 32'h10000, 32'h20000, -32'h30000, 32'h10000, 1, 1, 0));
		cmd_q.push_back(mk(OP_LEN, mn, mn, mn, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_LEN, 32'h30000, 32'h40000, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_LEN, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_LEN, 1, 1, 1, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_NORM, 0, 0, 0, mx, mx, mx, mx));
		cmd_q.push_back(mk(OP_NORM, mn, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_NORM, mx, mn, mx, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_NORM, 32'h30000, -32'h40000, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(3'd6, mx, mn, mx, mn, mx, mn, mx));
		cmd_q.push_back(mk(3'd7, -1, -1, -1, -1, -1, -1, -1));
		for (int i = 0; i < N_RANDOM; i++)
			cmd_q.push_back(rand_cmd());
		n_total = cmd_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all beats sent and all results seen, then wait in quiet before the verdict.
		while (cmd_q.size() != 0 || start || want_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
src/vec3_pkg.sv
src/vec3_front.sv
src/vec3_sqrt.sv
src/vec3_div.sv
src/vector3_alu.sv
dv/tb.sv
